@@ design/pcs_pkg.sv @@
package pcs_pkg;

  // Sample and fixed-point formats.
  localparam int unsigned ADC_BITS   = 12;
  localparam int unsigned OFS_FRAC   = 8;
  localparam int unsigned OFFSET_W   = ADC_BITS + OFS_FRAC;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned DIVIDEND_W = SUM_W + OFS_FRAC;
  localparam int unsigned DIV_STEP_W = $clog2(DIVIDEND_W);
  localparam int unsigned Q_W        = 24;
  localparam int unsigned Q_FRAC     = 16;
  localparam int unsigned VOLT_SHIFT = 8;
  localparam int unsigned ALPHA_W    = 17;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned MUL_A_W    = Q_W + 1;
  localparam int unsigned PROD_W     = MUL_A_W + SCALE_W + 1;
  localparam int unsigned NUM_PH     = 3;
  localparam int unsigned PH_W       = $clog2(NUM_PH);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CALIB_SAMPLES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LPF_ALPHA     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SCALE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_VBUS_SCALE    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SANE_LOW      = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SANE_HIGH     = CFG_IDX_W'(5);

  // Register reset values.
  localparam logic [CNT_W-1:0]    CALIB_SAMPLES_RST = CNT_W'(2000);
  localparam logic [ALPHA_W-1:0]  LPF_ALPHA_RST     = ALPHA_W'(6554);
  localparam logic [SCALE_W-1:0]  CURRENT_SCALE_RST = SCALE_W'(13526);
  localparam logic [SCALE_W-1:0]  VBUS_SCALE_RST    = SCALE_W'(0);
  localparam logic [ADC_BITS-1:0] SANE_LOW_RST      = ADC_BITS'(100);
  localparam logic [ADC_BITS-1:0] SANE_HIGH_RST     = ADC_BITS'(4000);

  // Mid-scale offset (2048.0 in Q12.8) and unity filter gain.
  localparam logic [OFFSET_W-1:0] OFFSET_RST = OFFSET_W'(1) << (OFFSET_W - 1);
  localparam logic [ALPHA_W-1:0]  ALPHA_ONE  = ALPHA_W'(1) << (ALPHA_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALIB,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_OUTPUT
  } pcs_state_e;

  typedef enum logic [1:0] {
    OP_CONV,
    OP_FILT,
    OP_VOLTS
  } pcs_op_e;

  typedef enum logic [1:0] {
    ALU_CURRENT,
    ALU_FILTER,
    ALU_VOLTS
  } pcs_alu_mode_e;

  typedef struct packed {
    logic                      start;
    pcs_alu_mode_e             mode;
    logic signed [MUL_A_W-1:0] op_a;
    logic [SCALE_W-1:0]        op_b;
    logic signed [Q_W-1:0]     addend;
  } pcs_alu_req_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [CNT_W-1:0]      divisor;
  } pcs_div_req_t;

endpackage

@@ design/pcs_if.sv @@
interface pcs_sample_if;
  import pcs_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] raw_phase_a;
  logic [ADC_BITS-1:0] raw_phase_b;
  logic [ADC_BITS-1:0] raw_phase_c;
  logic [ADC_BITS-1:0] raw_bus_volt;

  modport source (output valid, raw_phase_a, raw_phase_b, raw_phase_c, raw_bus_volt,
                  input ready);
  modport sink (input valid, raw_phase_a, raw_phase_b, raw_phase_c, raw_bus_volt,
                output ready);
endinterface

interface pcs_result_if;
  import pcs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] amps_a;
  logic signed [Q_W-1:0] amps_b;
  logic signed [Q_W-1:0] amps_c;
  logic signed [Q_W-1:0] smooth_a;
  logic signed [Q_W-1:0] smooth_b;
  logic signed [Q_W-1:0] smooth_c;
  logic [Q_W-1:0]        bus_volts;
  logic                  calibrated;

  modport source (output valid, amps_a, amps_b, amps_c, smooth_a, smooth_b, smooth_c,
                  bus_volts, calibrated, input ready);
  modport sink (input valid, amps_a, amps_b, amps_c, smooth_a, smooth_b, smooth_c,
                bus_volts, calibrated, output ready);
endinterface

interface pcs_cfg_if;
  import pcs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/phase_current_sense_calibrate_filter.sv @@
// An accepted item updates calibration; the one that completes it runs the offset
//   divisions on the bit-serial divider. Each item is then converted, filtered (the
//   first item seeds the filter) and the bus voltage scaled, on one shared multiplier.
//   Items go one at a time: a new one is taken after the last is loaded for output.
// Reset: clears offsets to mid-scale, sums, count and filter state, and loads the
//   register defaults; the block is ready as soon as reset is released.
module phase_current_sense_calibrate_filter (
  input logic          clk_i,
  input logic          rst_ni,
  pcs_cfg_if.sink      cfg_i,
  pcs_sample_if.sink   sample_i,
  pcs_result_if.source result_o
);
  import pcs_pkg::*;

  localparam logic [PH_W-1:0] PH_LAST = PH_W'(NUM_PH - 1);

  // Configuration registers.
  logic [CNT_W-1:0]    calib_samples_q;
  logic [ALPHA_W-1:0]  lpf_alpha_q;
  logic [SCALE_W-1:0]  current_scale_q;
  logic [SCALE_W-1:0]  vbus_scale_q;
  logic [ADC_BITS-1:0] sane_low_q;
  logic [ADC_BITS-1:0] sane_high_q;

  // Sequencer and calibration state.
  pcs_state_e             state_q, state_d;
  pcs_op_e                op_q, op_d;
  logic [PH_W-1:0]        ph_q, ph_d;
  logic [SUM_W-1:0]       sum_q [NUM_PH];
  logic [SUM_W-1:0]       sum_d [NUM_PH];
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   calib_q, calib_d;
  logic [OFFSET_W-1:0]    offset_q [NUM_PH];
  logic [OFFSET_W-1:0]    offset_d [NUM_PH];
  logic signed [Q_W-1:0]  filt_q [NUM_PH];
  logic signed [Q_W-1:0]  filt_d [NUM_PH];
  logic                   seeded_q, seeded_d;

  // Working values of the item in flight.
  logic [ADC_BITS-1:0]    raw_q [NUM_PH];
  logic [ADC_BITS-1:0]    raw_d [NUM_PH];
  logic [ADC_BITS-1:0]    raw_bus_q, raw_bus_d;
  logic signed [Q_W-1:0]  amps_q [NUM_PH];
  logic signed [Q_W-1:0]  amps_d [NUM_PH];
  logic [Q_W-1:0]         volts_q, volts_d;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  logic                   out_load;
  logic signed [Q_W-1:0]  out_amps_q [NUM_PH];
  logic signed [Q_W-1:0]  out_filt_q [NUM_PH];
  logic [Q_W-1:0]         out_volts_q;
  logic                   out_calib_q;

  // Shared units.
  pcs_div_req_t           div_req;
  logic                   div_done;
  logic [OFFSET_W-1:0]    div_quot;
  pcs_alu_req_t           alu_req;
  logic                   alu_done;
  logic [Q_W-1:0]         alu_result;

  logic                   sane;
  logic [CNT_W-1:0]       cnt_inc;
  logic [ALPHA_W-1:0]     alpha_eff;
  logic signed [OFFSET_W:0] conv_diff;

  assign cfg_i.ready    = 1'b1;
  assign sample_i.ready = (state_q == ST_IDLE);

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_samples_q <= CALIB_SAMPLES_RST;
      lpf_alpha_q     <= LPF_ALPHA_RST;
      current_scale_q <= CURRENT_SCALE_RST;
      vbus_scale_q    <= VBUS_SCALE_RST;
      sane_low_q      <= SANE_LOW_RST;
      sane_high_q     <= SANE_HIGH_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_CALIB_SAMPLES: calib_samples_q <= cfg_i.data[CNT_W-1:0];
        REG_LPF_ALPHA:     lpf_alpha_q     <= cfg_i.data[ALPHA_W-1:0];
        REG_CURRENT_SCALE: current_scale_q <= cfg_i.data[SCALE_W-1:0];
        REG_VBUS_SCALE:    vbus_scale_q    <= cfg_i.data[SCALE_W-1:0];
        REG_SANE_LOW:      sane_low_q      <= cfg_i.data[ADC_BITS-1:0];
        REG_SANE_HIGH:     sane_high_q     <= cfg_i.data[ADC_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign alpha_eff = (lpf_alpha_q > ALPHA_ONE) ? ALPHA_ONE : lpf_alpha_q;
  assign sane      = (raw_q[0] >= sane_low_q) && (raw_q[0] <= sane_high_q);
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign conv_diff = $signed({1'b0, raw_q[ph_q], {OFS_FRAC{1'b0}}})
                   - $signed({1'b0, offset_q[ph_q]});

  // Divider operands: rounded average sum * 256 / count for the current phase.
  assign div_req.start    = (state_q == ST_DIV_START);
  assign div_req.dividend = {sum_q[ph_q], {OFS_FRAC{1'b0}}} + DIVIDEND_W'(cnt_q >> 1);
  assign div_req.divisor  = cnt_q;

  // Multiplier operands for the current operation.
  always_comb begin
    alu_req.start  = (state_q == ST_MUL_START);
    alu_req.addend = filt_q[ph_q];
    case (op_q)
      OP_CONV: begin
        alu_req.mode = ALU_CURRENT;
        alu_req.op_a = MUL_A_W'(conv_diff);
        alu_req.op_b = current_scale_q;
      end
      OP_FILT: begin
        alu_req.mode = ALU_FILTER;
        alu_req.op_a = MUL_A_W'(amps_q[ph_q]) - MUL_A_W'(filt_q[ph_q]);
        alu_req.op_b = SCALE_W'(alpha_eff);
      end
      OP_VOLTS: begin
        alu_req.mode = ALU_VOLTS;
        alu_req.op_a = $signed({{(MUL_A_W-ADC_BITS){1'b0}}, raw_bus_q});
        alu_req.op_b = vbus_scale_q;
      end
      default: begin
        alu_req.mode = ALU_CURRENT;
        alu_req.op_a = '0;
        alu_req.op_b = '0;
      end
    endcase
  end

  pcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  pcs_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  // Sequencer: calibration update, offset divisions, then the multiply steps.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    ph_d      = ph_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    calib_d   = calib_q;
    offset_d  = offset_q;
    filt_d    = filt_q;
    seeded_d  = seeded_q;
    raw_d     = raw_q;
    raw_bus_d = raw_bus_q;
    amps_d    = amps_q;
    volts_d   = volts_q;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          raw_d[0]  = sample_i.raw_phase_a;
          raw_d[1]  = sample_i.raw_phase_b;
          raw_d[2]  = sample_i.raw_phase_c;
          raw_bus_d = sample_i.raw_bus_volt;
          state_d   = ST_CALIB;
        end
      end
      ST_CALIB: begin
        ph_d    = '0;
        op_d    = OP_CONV;
        state_d = ST_MUL_START;
        if (!calib_q && sane) begin
          for (int i = 0; i < NUM_PH; i++) begin
            sum_d[i] = sum_q[i] + SUM_W'(raw_q[i]);
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= calib_samples_q && cnt_inc != '0) begin
            calib_d = 1'b1;
            state_d = ST_DIV_START;
          end
        end
      end
      ST_DIV_START: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          offset_d[ph_q] = div_quot;
          if (ph_q == PH_LAST) begin
            ph_d    = '0;
            state_d = ST_MUL_START;
          end else begin
            ph_d    = ph_q + PH_W'(1);
            state_d = ST_DIV_START;
          end
        end
      end
      ST_MUL_START: begin
        state_d = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (alu_done) begin
          state_d = ST_MUL_START;
          case (op_q)
            OP_CONV: begin
              amps_d[ph_q] = alu_result;
              if (ph_q == PH_LAST) begin
                ph_d = '0;
                op_d = seeded_q ? OP_FILT : OP_VOLTS;
              end else begin
                ph_d = ph_q + PH_W'(1);
              end
            end
            OP_FILT: begin
              filt_d[ph_q] = alu_result;
              if (ph_q == PH_LAST) begin
                ph_d = '0;
                op_d = OP_VOLTS;
              end else begin
                ph_d = ph_q + PH_W'(1);
              end
            end
            OP_VOLTS: begin
              volts_d = alu_result;
              // The first item seeds the filters with its own currents.
              if (!seeded_q) begin
                filt_d   = amps_q;
                seeded_d = 1'b1;
              end
              state_d = ST_OUTPUT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_OUTPUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and calibration state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_CONV;
      ph_q        <= '0;
      cnt_q       <= '0;
      calib_q     <= 1'b0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_PH; i++) begin
        sum_q[i]    <= '0;
        offset_q[i] <= OFFSET_RST;
        filt_q[i]   <= '0;
      end
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      ph_q        <= ph_d;
      cnt_q       <= cnt_d;
      calib_q     <= calib_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
      offset_q    <= offset_d;
      filt_q      <= filt_d;
    end
  end

  // Item payload and result registers.
  always_ff @(posedge clk_i) begin
    raw_q     <= raw_d;
    raw_bus_q <= raw_bus_d;
    amps_q    <= amps_d;
    volts_q   <= volts_d;
    if (out_load) begin
      out_amps_q  <= amps_q;
      out_filt_q  <= filt_d;
      out_volts_q <= volts_d;
      out_calib_q <= calib_q;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.amps_a     = out_amps_q[0];
  assign result_o.amps_b     = out_amps_q[1];
  assign result_o.amps_c     = out_amps_q[2];
  assign result_o.smooth_a   = out_filt_q[0];
  assign result_o.smooth_b   = out_filt_q[1];
  assign result_o.smooth_c   = out_filt_q[2];
  assign result_o.bus_volts  = out_volts_q;
  assign result_o.calibrated = out_calib_q;

endmodule

@@ design/pcs_div.sv @@
module pcs_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pcs_pkg::pcs_div_req_t        req_i,
  output logic                         done_o,
  output logic [pcs_pkg::OFFSET_W-1:0] quot_o
);
  import pcs_pkg::*;

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]      rem_q, rem_d;
  logic [CNT_W-1:0]      div_q, div_d;
  logic [DIV_STEP_W-1:0] step_q, step_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W:0]        trial;
  logic [CNT_W:0]        diff;
  logic                  qbit;

  // One restoring-division step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign qbit  = ~diff[CNT_W];

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
      step_d = DIV_STEP_W'(DIVIDEND_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[DIVIDEND_W-2:0], qbit};
      rem_d  = qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      step_d = step_q - DIV_STEP_W'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  // The average never exceeds full scale, so the low bits hold the whole quotient.
  assign done_o = done_q;
  assign quot_o = quo_q[OFFSET_W-1:0];

endmodule

@@ design/pcs_alu.sv @@
module pcs_alu (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pcs_pkg::pcs_alu_req_t   req_i,
  output logic                    done_o,
  output logic [pcs_pkg::Q_W-1:0] result_o
);
  import pcs_pkg::*;

  localparam logic signed [PROD_W-1:0] RND_Q16  = PROD_W'(1) << (Q_FRAC - 1);
  localparam logic signed [PROD_W-1:0] RND_VOLT = PROD_W'(1) << (VOLT_SHIFT - 1);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [Q_W-1:0]    addend_q;
  pcs_alu_mode_e            mode_q;
  logic                     prod_vld_q;
  logic                     done_q;
  logic [Q_W-1:0]           result_q, result_d;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-1:0] shifted;
  logic signed [PROD_W-1:0] total;

  // Stage 1: the shared multiplier.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q   <= PROD_W'(req_i.op_a) * PROD_W'($signed({1'b0, req_i.op_b}));
      addend_q <= req_i.addend;
      mode_q   <= req_i.mode;
    end
  end

  // Stage 2: round half up, scale down, add the filter state in filter mode and saturate.
  always_comb begin
    rounded  = prod_q + ((mode_q == ALU_VOLTS) ? RND_VOLT : RND_Q16);
    shifted  = (mode_q == ALU_VOLTS) ? (rounded >>> VOLT_SHIFT) : (rounded >>> Q_FRAC);
    total    = shifted + ((mode_q == ALU_FILTER) ? PROD_W'(addend_q) : '0);
    result_d = total[Q_W-1:0];
    case (mode_q)
      ALU_VOLTS: begin
        if (total[PROD_W-1:Q_W] != '0) begin
          result_d = '1;
        end
      end
      ALU_CURRENT, ALU_FILTER: begin
        if (total[PROD_W-1:Q_W-1] != '0 && total[PROD_W-1:Q_W-1] != '1) begin
          result_d = total[PROD_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end
      end
      default: result_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      prod_vld_q <= req_i.start;
      done_q     <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_vld_q) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

@@ design/pcs_checker.sv @@
module pcs_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [pcs_pkg::Q_W-1:0] out_amps_a_i,
  input logic [pcs_pkg::Q_W-1:0] out_bus_volts_i,
  input logic                  out_calibrated_i
);
  import pcs_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;
  logic       seen_cal_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Items taken in but not yet delivered, and whether calibration was ever reported.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      seen_cal_q <= 1'b0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
      if (out_acc && out_calibrated_i) begin
        seen_cal_q <= 1'b1;
      end
    end
  end

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_amps_a_i)
      && $stable(out_bus_volts_i) && $stable(out_calibrated_i))
    else $error("result changed while stalled");

  // One item at a time: no new item right after one is taken.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input ready right after an accept");

  // A result is only offered for an item that was taken in.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without a pending item");

  // Calibration, once reported, is never withdrawn.
  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_cal_q |-> out_calibrated_i)
    else $error("calibrated flag dropped");

endmodule

bind phase_current_sense_calibrate_filter pcs_checker u_pcs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (sample_i.valid),
  .in_ready_i       (sample_i.ready),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .out_amps_a_i     (result_o.amps_a),
  .out_bus_volts_i  (result_o.bus_volts),
  .out_calibrated_i (result_o.calibrated)
);

@@ tb/sv/current_sense_checker.sv @@
`timescale 1ns / 100ps

module current_sense_checker
  import pcs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  pcs_cfg_if    cfg_i,
  pcs_sample_if sample_i,
  pcs_result_if result_i,
  output int    errors_o,
  output int    pending_o,
  output int    checked_o
);

  localparam longint AMP_MAX  = (longint'(1) <<< (Q_W - 1)) - 1;
  localparam longint AMP_MIN  = -(longint'(1) <<< (Q_W - 1));
  localparam longint VOLT_MAX = (longint'(1) <<< Q_W) - 1;

  typedef struct {
    logic signed [Q_W-1:0] amps   [NUM_PH];
    logic signed [Q_W-1:0] smooth [NUM_PH];
    logic [Q_W-1:0]        volts;
    logic                  calibrated;
  } reading_t;

  // Register copies as seen on the configuration channel.
  logic [CNT_W-1:0]    calib_total;
  logic [ALPHA_W-1:0]  alpha_reg;
  logic [SCALE_W-1:0]  amp_scale;
  logic [SCALE_W-1:0]  volt_scale;
  logic [ADC_BITS-1:0] win_lo;
  logic [ADC_BITS-1:0] win_hi;

  // Calibration and filter state of the block.
  logic [SUM_W-1:0]      phase_sum [NUM_PH];
  logic [CNT_W-1:0]      accepted_cnt;
  logic                  offsets_done;
  logic [OFFSET_W-1:0]   offset_q  [NUM_PH];
  logic signed [Q_W-1:0] smooth_q  [NUM_PH];
  logic                  smooth_primed;

  reading_t readings_due [$];
  int       err_count;
  int       checked_count;

  // Round to nearest with ties toward plus infinity, then drop n bits.
  function automatic longint round_shift(longint x, int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [Q_W-1:0] clamp_amps(longint v);
    if (v > AMP_MAX) return Q_W'(AMP_MAX);
    if (v < AMP_MIN) return Q_W'(AMP_MIN);
    return Q_W'(v);
  endfunction

  function automatic logic signed [Q_W-1:0] to_amps(logic [ADC_BITS-1:0] raw,
                                                     logic [OFFSET_W-1:0] ofs);
    longint diff;
    diff = (longint'(raw) <<< OFS_FRAC) - longint'(ofs);
    return clamp_amps(round_shift(diff * longint'(amp_scale), Q_FRAC));
  endfunction

  function automatic logic signed [Q_W-1:0] smooth_step(logic signed [Q_W-1:0] prev,
                                                         logic signed [Q_W-1:0] amp,
                                                         longint alpha);
    longint d;
    d = longint'(amp) - longint'(prev);
    return clamp_amps(longint'(prev) + round_shift(d * alpha, Q_FRAC));
  endfunction

  // Works out the result of one sample set and advances the state.
  function automatic reading_t next_reading(logic [ADC_BITS-1:0] raw [NUM_PH],
                                            logic [ADC_BITS-1:0] raw_volt);
    reading_t r;
    longint   alpha;
    longint   volts;
    int       p;
    alpha = (alpha_reg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_reg);

    // Calibration is updated first; the conversion uses the new offsets.
    if (!offsets_done && raw[0] >= win_lo && raw[0] <= win_hi) begin
      for (p = 0; p < NUM_PH; p++) begin
        phase_sum[p] = phase_sum[p] + SUM_W'(raw[p]);
      end
      accepted_cnt = accepted_cnt + CNT_W'(1);
      if (accepted_cnt != '0 && accepted_cnt >= calib_total) begin
        for (p = 0; p < NUM_PH; p++) begin
          offset_q[p] = OFFSET_W'(((longint'(phase_sum[p]) <<< OFS_FRAC)
                                   + longint'(accepted_cnt >> 1)) / longint'(accepted_cnt));
        end
        offsets_done = 1'b1;
      end
    end

    // The first converted set seeds the filter.
    for (p = 0; p < NUM_PH; p++) begin
      r.amps[p]   = to_amps(raw[p], offset_q[p]);
      smooth_q[p] = smooth_primed ? smooth_step(smooth_q[p], r.amps[p], alpha) : r.amps[p];
      r.smooth[p] = smooth_q[p];
    end
    smooth_primed = 1'b1;

    volts = (longint'(raw_volt) * longint'(volt_scale)
             + (longint'(1) <<< (VOLT_SHIFT - 1))) >>> VOLT_SHIFT;
    r.volts      = (volts > VOLT_MAX) ? Q_W'(VOLT_MAX) : Q_W'(volts);
    r.calibrated = offsets_done;
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t            want;
    reading_t            seen;
    logic [ADC_BITS-1:0] raw_ph [NUM_PH];
    int                  p;
    if (!rst_ni) begin
      calib_total   = CALIB_SAMPLES_RST;
      alpha_reg     = LPF_ALPHA_RST;
      amp_scale     = CURRENT_SCALE_RST;
      volt_scale    = VBUS_SCALE_RST;
      win_lo        = SANE_LOW_RST;
      win_hi        = SANE_HIGH_RST;
      accepted_cnt  = '0;
      offsets_done  = 1'b0;
      smooth_primed = 1'b0;
      for (p = 0; p < NUM_PH; p++) begin
        phase_sum[p] = '0;
        offset_q[p]  = OFFSET_RST;
        smooth_q[p]  = '0;
      end
      readings_due.delete();
      err_count     = 0;
      checked_count = 0;
    end else begin
      // Results are matched before this edge's sample set is queued.
      if (result_i.valid && result_i.ready) begin
        seen.amps[0]    = result_i.amps_a;
        seen.amps[1]    = result_i.amps_b;
        seen.amps[2]    = result_i.amps_c;
        seen.smooth[0]  = result_i.smooth_a;
        seen.smooth[1]  = result_i.smooth_b;
        seen.smooth[2]  = result_i.smooth_c;
        seen.volts      = result_i.bus_volts;
        seen.calibrated = result_i.calibrated;
        if (readings_due.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, got amps_a %0d", $time,
                   seen.amps[0]);
        end else begin
          want = readings_due.pop_front();
          for (p = 0; p < NUM_PH; p++) begin
            check_field($sformatf("amps[%0d]", p), want.amps[p], seen.amps[p]);
            check_field($sformatf("smooth[%0d]", p), want.smooth[p], seen.smooth[p]);
          end
          check_field("bus_volts", want.volts, seen.volts);
          check_field("calibrated", want.calibrated, seen.calibrated);
          checked_count++;
        end
      end

      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_CALIB_SAMPLES: calib_total = cfg_i.data[CNT_W-1:0];
          REG_LPF_ALPHA:     alpha_reg   = cfg_i.data[ALPHA_W-1:0];
          REG_CURRENT_SCALE: amp_scale   = cfg_i.data[SCALE_W-1:0];
          REG_VBUS_SCALE:    volt_scale  = cfg_i.data[SCALE_W-1:0];
          REG_SANE_LOW:      win_lo      = cfg_i.data[ADC_BITS-1:0];
          REG_SANE_HIGH:     win_hi      = cfg_i.data[ADC_BITS-1:0];
          default: ;
        endcase
      end

      if (sample_i.valid && sample_i.ready) begin
        raw_ph[0] = sample_i.raw_phase_a;
        raw_ph[1] = sample_i.raw_phase_b;
        raw_ph[2] = sample_i.raw_phase_c;
        readings_due.push_back(next_reading(raw_ph, sample_i.raw_bus_volt));
      end
    end
    errors_o  <= err_count;
    pending_o <= readings_due.size();
    checked_o <= checked_count;
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import pcs_pkg::*;

  localparam int unsigned SEGMENTS       = 8;
  localparam int unsigned SEGMENT_ITEMS  = 98;
  localparam int unsigned IDLE_PCT       = 13;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned SETTLE_CYCLES  = 200;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned ADC_MAX        = (1 << ADC_BITS) - 1;
  localparam int unsigned SCALE_MAX      = (1 << SCALE_W) - 1;
  localparam int unsigned ALPHA_MAX      = (1 << ALPHA_W) - 1;
  localparam int unsigned CNT_MAX        = (1 << CNT_W) - 1;

  typedef struct packed {
    logic [ADC_BITS-1:0] a;
    logic [ADC_BITS-1:0] b;
    logic [ADC_BITS-1:0] c;
    logic [ADC_BITS-1:0] v;
  } adc_set_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pcs_cfg_if    cfg_ch ();
  pcs_sample_if sample_ch ();
  pcs_result_if result_ch ();

  int   mismatches;
  int   outstanding;
  int   checked;
  bit   steady;
  int   hold_tokens = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   sets_sent = 0;
  int   settings_used = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  phase_current_sense_calibrate_filter uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_ch),
    .sample_i (sample_ch),
    .result_o (result_ch)
  );

  current_sense_checker checker_inst (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_ch),
    .sample_i  (sample_ch),
    .result_i  (result_ch),
    .errors_o  (mismatches),
    .pending_o (outstanding),
    .checked_o (checked)
  );

  // Result side: random stalls, a requested long hold-off, or always ready.
  always @(posedge clk_i) begin
    if (hold_seen != hold_tokens) begin
      hold_seen = hold_tokens;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (steady) begin
      result_ch.ready <= 1'b1;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Ends the run when no channel moves an item for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Offers one sample set, after a random gap unless idling is off.
  task automatic send_set(input adc_set_t s);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        sample_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.raw_phase_a  <= s.a;
    sample_ch.raw_phase_b  <= s.b;
    sample_ch.raw_phase_c  <= s.c;
    sample_ch.raw_bus_volt <= s.v;
    do @(posedge clk_i); while (!(sample_ch.valid && sample_ch.ready));
    sets_sent++;
  endtask

  // Stops offering and waits until every result has come back.
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Valid stays high across a batch of writes and drops after the last.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
  endtask

  task automatic write_settings(input int unsigned calib, input int unsigned alpha,
                                input int unsigned amp_scale, input int unsigned volt_scale,
                                input int unsigned lo, input int unsigned hi);
    write_reg(REG_CALIB_SAMPLES, calib);
    write_reg(REG_LPF_ALPHA, alpha);
    write_reg(REG_CURRENT_SCALE, amp_scale);
    write_reg(REG_VBUS_SCALE, volt_scale);
    write_reg(REG_SANE_LOW, lo);
    write_reg(REG_SANE_HIGH, hi);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  function automatic int unsigned pick_alpha();
    case ($urandom_range(4))
      0:       return 0;
      1:       return ALPHA_ONE;
      2:       return ALPHA_MAX;
      3:       return $urandom_range(8000, 1);
      default: return $urandom_range(ALPHA_MAX);
    endcase
  endfunction

  function automatic int unsigned pick_scale();
    case ($urandom_range(4))
      0:       return 0;
      1:       return SCALE_MAX;
      2, 3:    return $urandom_range(60000, 1);
      default: return $urandom_range(SCALE_MAX);
    endcase
  endfunction

  // Mostly readings near mid-scale, as a motor at rest gives; some full range.
  function automatic logic [ADC_BITS-1:0] pick_raw(int unsigned kind);
    if (kind < 70) return ADC_BITS'(1848 + $urandom_range(400));
    if (kind < 90) return ADC_BITS'($urandom_range(ADC_MAX));
    return $urandom_range(1) ? ADC_BITS'(ADC_MAX) : ADC_BITS'(0);
  endfunction

  function automatic adc_set_t pick_set();
    int unsigned kind;
    kind = $urandom_range(99);
    return {pick_raw(kind), pick_raw(kind), pick_raw(kind), ADC_BITS'($urandom_range(ADC_MAX))};
  endfunction

  initial begin
    int unsigned calib_total;
    int unsigned win_lo;
    int unsigned win_hi;
    rst_ni                 = 1'b0;
    steady                 = 1'b0;
    sample_ch.valid        = 1'b0;
    sample_ch.raw_phase_a  = '0;
    sample_ch.raw_phase_b  = '0;
    sample_ch.raw_phase_c  = '0;
    sample_ch.raw_bus_volt = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = REG_CALIB_SAMPLES;
    cfg_ch.data            = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty calibration window, full-scale gains and a frozen filter.
    write_settings(CNT_MAX, 0, SCALE_MAX, SCALE_MAX, ADC_MAX, 0);
    send_set({12'd0, 12'd0, 12'd0, 12'd0});
    send_set({12'd4095, 12'd4095, 12'd4095, 12'd4095});
    send_set({12'd2048, 12'd2048, 12'd2048, 12'd2048});
    send_set({12'd4095, 12'd0, 12'd2047, 12'd1});
    send_set({12'd0, 12'd4095, 12'd1, 12'd4094});
    send_set({12'd2049, 12'd2047, 12'd1365, 12'd2730});
    wait_drained();

    // Window edges: readings just outside are skipped, the bounds are summed.
    // Alpha above unity, zero current gain.
    write_settings(CNT_MAX, ALPHA_MAX, 0, 1, 1000, 3000);
    send_set({12'd999, 12'd2100, 12'd1990, 12'd1365});
    send_set({12'd3001, 12'd2000, 12'd2000, 12'd2730});
    send_set({12'd1000, 12'd1900, 12'd2200, 12'd4095});
    send_set({12'd3000, 12'd2300, 12'd1800, 12'd0});
    send_set({12'd2048, 12'd2048, 12'd2048, 12'd2048});
    send_set({12'd1500, 12'd4095, 12'd0, 12'd100});
    wait_drained();

    // Four sets are summed by now. Either drop the threshold below that
    // count, zero included, so the next summed set finishes, or leave a
    // longer calibration to the random part.
    if ($urandom_range(2) != 0) begin
      calib_total = $urandom_range(3, 0);
    end else begin
      calib_total = 4 + $urandom_range(120, 16);
    end
    win_lo = 1000;
    win_hi = 3000;
    write_settings(calib_total, ALPHA_ONE, CURRENT_SCALE_RST, 24'h800000, win_lo, win_hi);
    send_set({12'd2048, 12'd2049, 12'd2047, 12'd4095});
    send_set({12'd1200, 12'd1000, 12'd3000, 12'd1});
    send_set({12'd2900, 12'd2500, 12'd1600, 12'd2000});
    send_set({12'd1024, 12'd3072, 12'd512, 12'd3500});

    // Random part: the calibration settings hold for the first segments.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      if (seg >= 3) begin
        calib_total = $urandom_range(CNT_MAX);
        win_lo      = $urandom_range(ADC_MAX);
        win_hi      = $urandom_range(ADC_MAX);
      end
      write_settings(calib_total, pick_alpha(), pick_scale(), pick_scale(), win_lo, win_hi);
      steady = (seg == 5);
      if (seg == 2) begin
        hold_tokens <= hold_tokens + 1;
      end
      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
        if (seg == 6 && i == SEGMENT_ITEMS / 2) begin
          wait_drained();
        end
        send_set(pick_set());
      end
    end
    steady = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run covered %0d sample sets over %0d register settings, %0d results checked",
             sets_sent, settings_used, checked);
    $display("calibration threshold %0d, output held off once for %0d cycles",
             calib_total, HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
